// ===== rtl/core/pressure_temperature_compensation_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Pressure/temperature compensation unit: assertion macros
// Immediate-style wrappers around concurrent assertions, clocked on i_clk,
// disabled during reset. They expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PTC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptc assertion failed");
`define PTC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptc assertion failed");
`else
`define PTC_ASSERT_NOW(name, ante, cons)
`define PTC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== rtl/core/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, register indexes, constants and controller/datapath types.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int REF_W     = 18;
    localparam int PRES_W    = 24;
    localparam int TEMP_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_C1  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C2  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C3  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C4  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C5  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C6  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REF = 3'd6;

    localparam int REF_PRESSURE_RST = 101325;
    localparam int T_BASE           = 2000;   // 20.00 C
    localparam int T_LOW_OFS        = 1500;
    localparam int T_VCOLD_MAX      = -1600;  // temp <= -16.00 C

    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    typedef enum logic [4:0] {
        STEP_IDLE,
        STEP_LOAD,
        STEP_DT,
        STEP_MUL_SENS,
        STEP_MUL_OFF,
        STEP_MUL_TEMP,
        STEP_MUL_DT2,
        STEP_MUL_T2,
        STEP_MUL_T3,
        STEP_LOW_TEMP,
        STEP_MUL_PLO,
        STEP_MUL_PHI,
        STEP_SUM,
        STEP_SCALE,
        STEP_PRES,
        STEP_ALIGN,
        STEP_RESULT,
        STEP_REJECT
    } t_step;

    typedef struct packed {
        t_step step;
    } t_dp_cmd;

    typedef struct packed {
        logic pair_zero;
    } t_dp_sts;

endpackage

// ===== rtl/core/ptc_datapath.sv =====
// ----------------------------------------------------------------------------
// ptc_datapath
// Calibration registers, one shared 26x26 signed multiplier and compensation regs,
// stepped by the controller one operation per cycle unless output is stalled.
// ----------------------------------------------------------------------------
module ptc_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptc_pkg::t_dp_cmd                   i_cmd,
    output ptc_pkg::t_dp_sts                   o_sts,
    input  logic [ptc_pkg::RAW_W-1:0]          i_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]          i_raw_temperature,
    input  logic                               i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptc_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output logic signed [ptc_pkg::PRES_W-1:0]  o_pressure_pa,
    output logic signed [ptc_pkg::TEMP_W-1:0]  o_temperature_centi,
    output logic                               o_status
);
    import ptc_pkg::*;

    // truncating division by 2^k
    function automatic logic signed [63:0] f_div_pow2(input logic signed [63:0] x,
                                                      input int unsigned k);
        logic signed [63:0] bias;
        bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (x + bias) >>> k;
    endfunction

    logic [CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic [REF_W-1:0] r_ref;

    logic [RAW_W-1:0]          r_d1, r_d2;
    logic signed [MUL_W-1:0]   r_dt;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [43:0]        r_sens, r_off;
    logic signed [19:0]        r_temp, r_ti;
    logic signed [63:0]        r_acc;
    logic signed [47:0]        r_rawp;
    logic signed [31:0]        r_align;
    logic                      r_latched;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic                      cold, vcold;
    logic signed [63:0]        p64, t64, offi, sensi, p_val, diff;

    assign cold  = r_temp < 20'(T_BASE);
    assign vcold = r_temp <= 20'(T_VCOLD_MAX);
    assign p64   = 64'(r_prod);
    assign o_sts.pair_zero = (r_d1 == '0) && (r_d2 == '0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.step)
            STEP_MUL_SENS: begin
                mul_a = $signed({10'b0, r_c3});
                mul_b = r_dt;
            end
            STEP_MUL_OFF: begin
                mul_a = $signed({10'b0, r_c4});
                mul_b = r_dt;
            end
            STEP_MUL_TEMP: begin
                mul_a = r_dt;
                mul_b = $signed({10'b0, r_c6});
            end
            STEP_MUL_DT2: begin
                mul_a = r_dt;
                mul_b = r_dt;
            end
            STEP_MUL_T2: begin
                mul_a = 26'(r_temp) - 26'(T_BASE);
                mul_b = 26'(r_temp) - 26'(T_BASE);
            end
            STEP_MUL_T3: begin
                mul_a = 26'(r_temp) + 26'(T_LOW_OFS);
                mul_b = 26'(r_temp) + 26'(T_LOW_OFS);
            end
            STEP_MUL_PLO: begin
                mul_a = $signed({2'b0, r_d1});
                mul_b = $signed({6'b0, r_sens[19:0]});
            end
            STEP_MUL_PHI: begin
                mul_a = $signed({2'b0, r_d1});
                mul_b = 26'($signed(r_sens[43:20]));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // second-order terms from (temp - T_BASE)^2 (held in r_prod during STEP_MUL_T3)
    always_comb begin
        t64 = p64;
        if (cold) begin
            offi  = (t64 + (t64 <<< 1)) >>> 1;
            sensi = (t64 + (t64 <<< 2)) >>> 3;
        end else begin
            offi  = t64 >>> 4;
            sensi = '0;
        end
        p_val = f_div_pow2(r_acc, 13);
        diff  = 64'(r_rawp) - $signed({46'b0, r_ref});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1      <= '0;
            r_c2      <= '0;
            r_c3      <= '0;
            r_c4      <= '0;
            r_c5      <= '0;
            r_c6      <= '0;
            r_ref     <= REF_W'(REF_PRESSURE_RST);
            r_align   <= '0;
            r_latched <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_C1:  r_c1  <= i_cfg_data[CAL_W-1:0];
                    REG_C2:  r_c2  <= i_cfg_data[CAL_W-1:0];
                    REG_C3:  r_c3  <= i_cfg_data[CAL_W-1:0];
                    REG_C4:  r_c4  <= i_cfg_data[CAL_W-1:0];
                    REG_C5:  r_c5  <= i_cfg_data[CAL_W-1:0];
                    REG_C6:  r_c6  <= i_cfg_data[CAL_W-1:0];
                    REG_REF: r_ref <= i_cfg_data[REF_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.step == STEP_ALIGN && !r_latched && r_rawp > 48'sd0) begin
                r_latched <= 1'b1;
                if (diff > 64'sd2147483647)
                    r_align <= 32'sh7FFFFFFF;
                else if (diff < -64'sd2147483648)
                    r_align <= 32'sh80000000;
                else
                    r_align <= 32'(diff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (i_cmd.step)
            STEP_LOAD: begin
                r_d1 <= i_raw_pressure;
                r_d2 <= i_raw_temperature;
            end
            STEP_DT:
                r_dt <= $signed({2'b0, r_d2}) - $signed({2'b0, r_c5, 8'b0});
            STEP_MUL_OFF:
                r_sens <= $signed({13'b0, r_c1, 15'b0}) + 44'(f_div_pow2(p64, 8));
            STEP_MUL_TEMP:
                r_off <= $signed({12'b0, r_c2, 16'b0}) + 44'(f_div_pow2(p64, 7));
            STEP_MUL_DT2:
                r_temp <= 20'(T_BASE) + 20'(f_div_pow2(p64, 23));
            STEP_MUL_T2: begin
                // dt*dt is never negative, plain shifts truncate
                if (cold)
                    r_ti <= 20'((p64 + (p64 <<< 1)) >>> 33);
                else
                    r_ti <= 20'(p64 >>> 36);
            end
            STEP_MUL_T3: begin
                r_off  <= r_off - 44'(offi);
                r_sens <= r_sens - 44'(sensi);
            end
            STEP_LOW_TEMP: begin
                if (vcold) begin
                    r_off  <= r_off - 44'((p64 <<< 3) - p64);
                    r_sens <= r_sens - 44'(p64 <<< 2);
                end
                r_temp <= r_temp - r_ti;
            end
            STEP_MUL_PHI:
                r_acc <= p64;
            STEP_SUM:
                r_acc <= r_acc + (p64 <<< 20);
            STEP_SCALE:
                r_acc <= f_div_pow2(r_acc, 21) - 64'(r_off);
            STEP_PRES:
                r_rawp <= 48'((p_val <<< 3) + (p_val <<< 1));
            STEP_RESULT: begin
                if (64'(r_rawp) - 64'(r_align) > 64'sd8388607)
                    o_pressure_pa <= 24'sh7FFFFF;
                else if (64'(r_rawp) - 64'(r_align) < -64'sd8388608)
                    o_pressure_pa <= 24'sh800000;
                else
                    o_pressure_pa <= 24'(64'(r_rawp) - 64'(r_align));
                if (r_temp > 20'sd32767)
                    o_temperature_centi <= 16'sh7FFF;
                else if (r_temp < -20'sd32768)
                    o_temperature_centi <= 16'sh8000;
                else
                    o_temperature_centi <= 16'(r_temp);
                o_status <= 1'b0;
            end
            STEP_REJECT: begin
                o_pressure_pa       <= '0;
                o_temperature_centi <= '0;
                o_status            <= 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/ptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptc_ctrl
// Sequencer: input/output handshakes and the step order of the datapath.
// ----------------------------------------------------------------------------
`include "pressure_temperature_compensation_unit_assert.svh"

module ptc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output ptc_pkg::t_dp_cmd o_cmd,
    input  ptc_pkg::t_dp_sts i_sts
);
    import ptc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_MSENS, S_MOFF, S_MTEMP, S_MDT2, S_MT2, S_MT3, S_LOWT,
        S_PLO, S_PHI, S_SUM, S_SCALE, S_PRES, S_ALIGN, S_WRITE, S_REJECT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        unique case (r_state)
            S_IDLE:   o_cmd.step = i_s_tvalid ? STEP_LOAD : STEP_IDLE;
            S_CHECK:  o_cmd.step = STEP_DT;
            S_MSENS:  o_cmd.step = STEP_MUL_SENS;
            S_MOFF:   o_cmd.step = STEP_MUL_OFF;
            S_MTEMP:  o_cmd.step = STEP_MUL_TEMP;
            S_MDT2:   o_cmd.step = STEP_MUL_DT2;
            S_MT2:    o_cmd.step = STEP_MUL_T2;
            S_MT3:    o_cmd.step = STEP_MUL_T3;
            S_LOWT:   o_cmd.step = STEP_LOW_TEMP;
            S_PLO:    o_cmd.step = STEP_MUL_PLO;
            S_PHI:    o_cmd.step = STEP_MUL_PHI;
            S_SUM:    o_cmd.step = STEP_SUM;
            S_SCALE:  o_cmd.step = STEP_SCALE;
            S_PRES:   o_cmd.step = STEP_PRES;
            S_ALIGN:  o_cmd.step = STEP_ALIGN;
            S_WRITE:  o_cmd.step = out_free ? STEP_RESULT : STEP_IDLE;
            S_REJECT: o_cmd.step = out_free ? STEP_REJECT : STEP_IDLE;
            default:  o_cmd.step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a new result takes the slot; otherwise the slot empties on accept
            if ((r_state == S_WRITE || r_state == S_REJECT) && out_free)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE:  if (i_s_tvalid) r_state <= S_CHECK;
                S_CHECK: r_state <= i_sts.pair_zero ? S_REJECT : S_MSENS;
                S_MSENS: r_state <= S_MOFF;
                S_MOFF:  r_state <= S_MTEMP;
                S_MTEMP: r_state <= S_MDT2;
                S_MDT2:  r_state <= S_MT2;
                S_MT2:   r_state <= S_MT3;
                S_MT3:   r_state <= S_LOWT;
                S_LOWT:  r_state <= S_PLO;
                S_PLO:   r_state <= S_PHI;
                S_PHI:   r_state <= S_SUM;
                S_SUM:   r_state <= S_SCALE;
                S_SCALE: r_state <= S_PRES;
                S_PRES:  r_state <= S_ALIGN;
                S_ALIGN: r_state <= S_WRITE;
                S_WRITE, S_REJECT: begin
                    if (out_free)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PTC_ASSERT_NEXT(a_accept_to_check, i_s_tvalid && o_s_tready, r_state == S_CHECK)
    `PTC_ASSERT_NOW(a_no_overwrite, o_cmd.step == STEP_RESULT || o_cmd.step == STEP_REJECT, out_free)
    `PTC_ASSERT_NEXT(a_write_done, (r_state == S_WRITE || r_state == S_REJECT) && out_free, r_state == S_IDLE && r_out_valid)

endmodule

// ===== rtl/core/pressure_temperature_compensation_unit.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Second-order pressure/temperature compensation with first-reading alignment.
//
//  channel  direction  handshake            payload
//  s        in         i_s_tvalid/o_s_tready  raw pressure, raw temperature
//  m        out        o_m_tvalid/i_m_tready  pressure, temperature, status
//  cfg      in         i_cfg_valid/o_cfg_ready  register index, data
//
// o_m_tvalid rises once the controller has stepped from S_CHECK to S_ALIGN,
// sharing one 26x26 multiplier, and written the result in S_WRITE; a rejected pair
// goes from S_CHECK to S_REJECT. Input is ready again right after the result is
// written, so no new item is taken before the last one is done. A finished
// result waits in the output register while the next item is taken; a second
// result stalls in its last step until the first has gone. Reset is synchronous,
// active low, and clears config to defaults and the alignment offset. The cfg
// port is always ready.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [23:0] pressure_pa, [39:24] temperature_centi
    output logic        o_m_tuser,   // [0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ptc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ptc_pkg::*;

    t_dp_cmd                   cmd;
    t_dp_sts                   sts;
    logic signed [PRES_W-1:0]  pressure_pa;
    logic signed [TEMP_W-1:0]  temperature_centi;

    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {temperature_centi, pressure_pa};

    ptc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ptc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_raw_pressure      (i_s_tdata[23:0]),
        .i_raw_temperature   (i_s_tdata[47:24]),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_pressure_pa       (pressure_pa),
        .o_temperature_centi (temperature_centi),
        .o_status            (o_m_tuser)
    );

endmodule
